/* hw/rtl/lse_pkg.sv */
package lse_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 12;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENHANCE_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SD_LOW       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SD_HIGH      = 3'd6;

  // Register reset values.
  localparam logic [3:0]  RST_WINDOW_SIZE  = 4'd9;
  localparam logic [9:0]  RST_ROW_WIDTH    = 10'd368;
  localparam logic [9:0]  RST_FRAME_ROWS   = 10'd248;
  localparam logic [7:0]  RST_ENHANCE_GAIN = 8'd64;
  localparam logic [11:0] RST_THRESHOLD    = 12'd0;

  // Frame height limit and the row counter width it implies.
  localparam int MAX_ROWS = 512;
  localparam int ROW_W    = 9;
  localparam int ROWS_W   = 10;

  // Quotient bits produced by the divider (mean and deviation are 8 bits).
  localparam int QUOT_W = 8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_SQ,
    S_CTR,
    S_MUL1,
    S_MUL2,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_DIVM_GO,
    S_DIVM_WAIT,
    S_DIVS_GO,
    S_DIVS_WAIT,
    S_ENH,
    S_OUT
  } lse_state_t;

endpackage

/* hw/rtl/lse_root.sv */
// Iterative integer square root, one result bit per cycle.
module lse_root import lse_pkg::*; #(
  parameter int X_W = 30,
  parameter int R_W = 15
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [X_W-1:0] x,
  output logic           done,
  output logic [R_W-1:0] root
);

  localparam int CNT_W = $clog2(R_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [X_W-1:0]   rem_r;
  logic [X_W-1:0]   acc_r;
  logic [X_W-1:0]   bit_r;
  logic [X_W:0]     trial;

  assign trial = {1'b0, acc_r} + {1'b0, bit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(R_W);
        rem_r  <= x;
        acc_r  <= '0;
        bit_r  <= X_W'(1) << (2 * (R_W - 1));
      end else if (busy_r) begin
        if ({1'b0, rem_r} >= trial) begin
          rem_r <= rem_r - trial[X_W-1:0];
          acc_r <= (acc_r >> 1) + bit_r;
        end else begin
          acc_r <= acc_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = acc_r[R_W-1:0];

endmodule

/* hw/rtl/lse_div.sv */
// Restoring divider for quotients known to fit in QUOT_W bits.
module lse_div import lse_pkg::*; #(
  parameter int N_W = 7,
  parameter int D_W = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [D_W-1:0]    dividend,
  input  logic [N_W-1:0]    divisor,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [D_W-1:0]    rem_r;
  logic [D_W-1:0]    dsh_r;
  logic [QUOT_W-1:0] quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUOT_W);
        rem_r  <= dividend;
        dsh_r  <= D_W'(divisor) << (QUOT_W - 1);
        quot_r <= '0;
      end else if (busy_r) begin
        if (rem_r >= dsh_r) begin
          rem_r  <= rem_r - dsh_r;
          quot_r <= {quot_r[QUOT_W-2:0], 1'b1};
        end else begin
          quot_r <= {quot_r[QUOT_W-2:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

/* hw/rtl/local_statistics_enhance.sv */
// Local-statistics contrast enhancement over a mirror-padded pixel stream.
// Input channel: one transaction per pixel (in_pixel, in_frame_start) in raster
// order; in_frame_start latches window size, row width and frame rows and
// restarts the position. Output channel: one transaction per pixel whose
// square window lies wholly inside the frame, carrying the local mean, the
// local standard deviation, the (possibly gained) centre pixel, the qualify
// flag and a flag on the last result of the frame.
// Sequence: a pixel that gives no result passes through the store reads, column
// update and write-back in the line and column-sum memories. A pixel that gives
// a result then goes on through the products, the iterative square root of
// width R (the root width, 15 with default parameters) and two passes of the
// shared 8-step divider.
// Reset clears the control state and loads the register reset values; the
// memories need no clearing, as the first row of each frame rebuilds the
// column sums and only pixels of the current frame are read back.
// The result sits in an output register: while the receiver stalls, the next
// pixel is still taken and worked on, and the block waits only when a newer
// result is ready and the previous one has not yet been taken.
module local_statistics_enhance import lse_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_WINDOW = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_pixel,
  input  logic                 in_frame_start,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_local_mean,
  output logic [7:0]           out_local_sd,
  output logic [7:0]           out_enhanced_pixel,
  output logic                 out_was_enhanced,
  output logic                 out_frame_end,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CW1   = $clog2(MAX_WIDTH + 1);
  localparam int GW    = (CW1 > 10) ? CW1 + 1 : 11;
  localparam int WW    = $clog2(MAX_WINDOW + 1);
  localparam int SL_W  = $clog2(MAX_WINDOW);
  localparam int LA_W  = $clog2(MAX_WINDOW * MAX_WIDTH);
  localparam int N_W   = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int CS_W  = $clog2(255 * MAX_WINDOW + 1);
  localparam int CQ_W  = $clog2(65025 * MAX_WINDOW + 1);
  localparam int S_W   = $clog2(255 * MAX_WINDOW * MAX_WINDOW + 1);
  localparam int Q_W   = $clog2(65025 * MAX_WINDOW * MAX_WINDOW + 1);
  localparam int X_W   = N_W + Q_W;
  localparam int R_W   = (X_W + 1) / 2;
  localparam int D_W   = N_W + QUOT_W;
  localparam int P_W   = CFG_W + N_W;
  localparam int L2_W  = 2 * P_W;
  localparam int XS_W  = X_W + 8;
  localparam int CMP_W = (L2_W > XS_W) ? L2_W : XS_W;
  localparam int ML_W  = (S_W + 4 > P_W) ? S_W + 4 : P_W;

  // Geometry clamps applied when the geometry is latched.
  function automatic logic [WW-1:0] clamp_win(input logic [3:0] v);
    logic [WW+3:0] t;
    t = (WW + 4)'(v);
    if (t < (WW + 4)'(3)) t = (WW + 4)'(3);
    if (t > (WW + 4)'(MAX_WINDOW)) t = (WW + 4)'(MAX_WINDOW);
    if (!t[0]) t = t - 1'b1;
    return t[WW-1:0];
  endfunction

  function automatic logic [CW1-1:0] clamp_width(input logic [9:0] v);
    logic [GW-1:0] t;
    t = GW'(v);
    if (t == '0) t = GW'(1);
    if (t > GW'(MAX_WIDTH)) t = GW'(MAX_WIDTH);
    return t[CW1-1:0];
  endfunction

  function automatic logic [ROWS_W-1:0] clamp_rows(input logic [9:0] v);
    logic [ROWS_W:0] t;
    t = (ROWS_W + 1)'(v);
    if (t == '0) t = (ROWS_W + 1)'(1);
    if (t > (ROWS_W + 1)'(MAX_ROWS)) t = (ROWS_W + 1)'(MAX_ROWS);
    return t[ROWS_W-1:0];
  endfunction

  // Configuration registers.
  logic [3:0]       cfg_win_r;
  logic [9:0]       cfg_width_r;
  logic [9:0]       cfg_rows_r;
  logic [7:0]       cfg_gain_r;
  logic [CFG_W-1:0] cfg_mean_lim_r;
  logic [CFG_W-1:0] cfg_sd_low_r;
  logic [CFG_W-1:0] cfg_sd_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_win_r      <= RST_WINDOW_SIZE;
      cfg_width_r    <= RST_ROW_WIDTH;
      cfg_rows_r     <= RST_FRAME_ROWS;
      cfg_gain_r     <= RST_ENHANCE_GAIN;
      cfg_mean_lim_r <= RST_THRESHOLD;
      cfg_sd_low_r   <= RST_THRESHOLD;
      cfg_sd_high_r  <= RST_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_SIZE:  cfg_win_r      <= cfg_wdata[3:0];
        CFG_ROW_WIDTH:    cfg_width_r    <= cfg_wdata[9:0];
        CFG_FRAME_ROWS:   cfg_rows_r     <= cfg_wdata[9:0];
        CFG_ENHANCE_GAIN: cfg_gain_r     <= cfg_wdata[7:0];
        CFG_MEAN_LIMIT:   cfg_mean_lim_r <= cfg_wdata;
        CFG_SD_LOW:       cfg_sd_low_r   <= cfg_wdata;
        CFG_SD_HIGH:      cfg_sd_high_r  <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // State machine.
  lse_state_t state_r, state_nxt;
  logic       in_accept;
  logic       out_free;
  logic       produce;
  logic       root_done;
  logic       div_done;

  assign in_accept = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (in_valid) state_nxt = S_RD;
      S_RD:        state_nxt = S_SQ;
      S_SQ:        state_nxt = S_CTR;
      S_CTR:       state_nxt = produce ? S_MUL1 : S_IDLE;
      S_MUL1:      state_nxt = S_MUL2;
      S_MUL2:      state_nxt = S_ROOT_GO;
      S_ROOT_GO:   state_nxt = S_ROOT_WAIT;
      S_ROOT_WAIT: if (root_done) state_nxt = S_DIVM_GO;
      S_DIVM_GO:   state_nxt = S_DIVM_WAIT;
      S_DIVM_WAIT: if (div_done) state_nxt = S_DIVS_GO;
      S_DIVS_GO:   state_nxt = S_DIVS_WAIT;
      S_DIVS_WAIT: if (div_done) state_nxt = S_ENH;
      S_ENH:       state_nxt = S_OUT;
      S_OUT:       if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Latched geometry and position of the pixel being worked on.
  logic [WW-1:0]     win_r;
  logic [N_W-1:0]    n_r;
  logic [CW1-1:0]    width_r;
  logic [ROWS_W-1:0] rows_r;
  logic [ROW_W-1:0]  row_r;
  logic [CW-1:0]     col_r;
  logic [SL_W-1:0]   slot_r;
  logic [WW-1:0]     win_new;

  assign win_new = clamp_win(cfg_win_r);

  // Position bookkeeping.
  logic [CW1-1:0]    col_inc;
  logic [ROWS_W-1:0] row_inc;
  logic              row_ge_w;
  logic              col_ge_w;
  logic              last_px;

  assign col_inc  = CW1'(col_r) + 1'b1;
  assign row_inc  = ROWS_W'(row_r) + 1'b1;
  assign row_ge_w = (ROWS_W'(row_r) >= ROWS_W'(win_r));
  assign col_ge_w = (CW1'(col_r) >= CW1'(win_r));
  assign produce  = (row_inc >= ROWS_W'(win_r)) && (col_inc >= CW1'(win_r));
  assign last_px  = (row_inc == rows_r) && (col_inc == width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= clamp_win(RST_WINDOW_SIZE);
      n_r     <= N_W'(clamp_win(RST_WINDOW_SIZE)) * N_W'(clamp_win(RST_WINDOW_SIZE));
      width_r <= clamp_width(RST_ROW_WIDTH);
      rows_r  <= clamp_rows(RST_FRAME_ROWS);
      row_r   <= '0;
      col_r   <= '0;
      slot_r  <= '0;
    end else if (in_accept && in_frame_start) begin
      win_r   <= win_new;
      n_r     <= N_W'(win_new) * N_W'(win_new);
      width_r <= clamp_width(cfg_width_r);
      rows_r  <= clamp_rows(cfg_rows_r);
      row_r   <= '0;
      col_r   <= '0;
      slot_r  <= '0;
    end else if (state_r == S_CTR) begin
      if (col_inc >= width_r) begin
        col_r <= '0;
        if (row_inc >= rows_r) begin
          row_r  <= '0;
          slot_r <= '0;
        end else begin
          row_r  <= row_inc[ROW_W-1:0];
          slot_r <= (slot_r == SL_W'(MAX_WINDOW - 1)) ? '0 : slot_r + 1'b1;
        end
      end else begin
        col_r <= col_inc[CW-1:0];
      end
    end
  end

  // Line store slots: the row that leaves the window and the centre row.
  logic [SL_W:0]   old_slot_t;
  logic [SL_W:0]   cen_slot_t;
  logic [SL_W-1:0] old_slot;
  logic [SL_W-1:0] cen_slot;
  logic [WW-1:0]   half;
  logic [CW-1:0]   cen_col;

  assign half       = win_r >> 1;
  assign old_slot_t = (SL_W + 1)'(slot_r) + (SL_W + 1)'(MAX_WINDOW) - (SL_W + 1)'(win_r);
  assign cen_slot_t = (SL_W + 1)'(slot_r) + (SL_W + 1)'(MAX_WINDOW) - (SL_W + 1)'(half);
  assign old_slot   = (old_slot_t >= (SL_W + 1)'(MAX_WINDOW)) ?
                      SL_W'(old_slot_t - (SL_W + 1)'(MAX_WINDOW)) : old_slot_t[SL_W-1:0];
  assign cen_slot   = (cen_slot_t >= (SL_W + 1)'(MAX_WINDOW)) ?
                      SL_W'(cen_slot_t - (SL_W + 1)'(MAX_WINDOW)) : cen_slot_t[SL_W-1:0];
  assign cen_col    = col_r - CW'(half);

  // Line store: MAX_WINDOW rows of pixels, one write and one read port.
  logic [7:0]      line_mem [MAX_WINDOW*MAX_WIDTH];
  logic [7:0]      line_rdata_r;
  logic            line_re;
  logic [LA_W-1:0] line_raddr;
  logic [LA_W-1:0] line_waddr;
  logic [7:0]      px_r;
  logic [15:0]     px_sq_r;

  assign line_re    = (state_r == S_RD) || ((state_r == S_SQ) && produce);
  assign line_raddr = (state_r == S_RD) ?
                      LA_W'(old_slot) * LA_W'(MAX_WIDTH) + LA_W'(col_r) :
                      LA_W'(cen_slot) * LA_W'(MAX_WIDTH) + LA_W'(cen_col);
  assign line_waddr = LA_W'(slot_r) * LA_W'(MAX_WIDTH) + LA_W'(col_r);

  always_ff @(posedge clk) begin
    if (state_r == S_CTR) line_mem[line_waddr] <= px_r;
    if (line_re) line_rdata_r <= line_mem[line_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      px_r    <= in_pixel;
      px_sq_r <= in_pixel * in_pixel;
    end
  end

  // Column store: running sum and sum of squares of the last rows per column.
  logic [CS_W+CQ_W-1:0] col_mem [MAX_WIDTH];
  logic [CS_W+CQ_W-1:0] col_rdata_r;
  logic [CS_W-1:0]      cs_rd;
  logic [CQ_W-1:0]      cq_rd;
  logic [CS_W-1:0]      cs_new;
  logic [CQ_W-1:0]      cq_new;
  logic [7:0]           old_px_r;
  logic [15:0]          old_sq_r;

  assign cs_rd  = col_rdata_r[CS_W+CQ_W-1:CQ_W];
  assign cq_rd  = col_rdata_r[CQ_W-1:0];
  assign cs_new = ((row_r == '0) ? '0 : cs_rd) + CS_W'(px_r)
                  - (row_ge_w ? CS_W'(old_px_r) : '0);
  assign cq_new = ((row_r == '0) ? '0 : cq_rd) + CQ_W'(px_sq_r)
                  - (row_ge_w ? CQ_W'(old_sq_r) : '0);

  always_ff @(posedge clk) begin
    if (state_r == S_CTR) col_mem[col_r] <= {cs_new, cq_new};
    if (state_r == S_RD)  col_rdata_r    <= col_mem[col_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SQ) begin
      old_px_r <= line_rdata_r;
      old_sq_r <= line_rdata_r * line_rdata_r;
    end
  end

  // Sliding window over the column sums of the current row.
  logic [CS_W-1:0] hist_s_r [MAX_WINDOW];
  logic [CQ_W-1:0] hist_q_r [MAX_WINDOW];
  logic [S_W-1:0]  wsum_r;
  logic [Q_W-1:0]  wsq_r;
  logic [SL_W-1:0] tap;
  logic [7:0]      centre_r;
  logic            frame_end_r;

  assign tap = SL_W'(win_r - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsum_r <= '0;
      wsq_r  <= '0;
    end else if (state_r == S_CTR) begin
      if (col_r == '0) begin
        wsum_r <= S_W'(cs_new);
        wsq_r  <= Q_W'(cq_new);
      end else begin
        wsum_r <= wsum_r + S_W'(cs_new) - (col_ge_w ? S_W'(hist_s_r[tap]) : '0);
        wsq_r  <= wsq_r + Q_W'(cq_new) - (col_ge_w ? Q_W'(hist_q_r[tap]) : '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CTR) begin
      hist_s_r[0] <= cs_new;
      hist_q_r[0] <= cq_new;
      for (int k = 1; k < MAX_WINDOW; k++) begin
        hist_s_r[k] <= hist_s_r[k-1];
        hist_q_r[k] <= hist_q_r[k-1];
      end
      centre_r    <= line_rdata_r;
      frame_end_r <= last_px;
    end
  end

  // Statistics: products, threshold tests, root and divisions.
  logic [X_W-1:0]  nq_r;
  logic [X_W-1:0]  ss_r;
  logic [X_W-1:0]  x_r;
  logic [P_W-1:0]  mln_r;
  logic [P_W-1:0]  lo_r;
  logic [P_W-1:0]  hi_r;
  logic [L2_W-1:0] lo2_r;
  logic [L2_W-1:0] hi2_r;
  logic            mean_ok_r;
  logic            ok_r;
  logic [R_W-1:0]  root;
  logic [R_W-1:0]  root_r;
  logic [QUOT_W-1:0] quot;
  logic [7:0]      mean_r;
  logic [7:0]      sd_r;
  logic [15:0]     prod_r;
  logic [CMP_W-1:0] x256;

  assign x256 = CMP_W'(x_r) << 8;

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_MUL1: begin
        nq_r  <= X_W'(n_r) * X_W'(wsq_r);
        ss_r  <= X_W'(wsum_r) * X_W'(wsum_r);
        mln_r <= P_W'(cfg_mean_lim_r) * P_W'(n_r);
        lo_r  <= P_W'(cfg_sd_low_r) * P_W'(n_r);
        hi_r  <= P_W'(cfg_sd_high_r) * P_W'(n_r);
      end
      S_MUL2: begin
        x_r       <= nq_r - ss_r;
        lo2_r     <= L2_W'(lo_r) * L2_W'(lo_r);
        hi2_r     <= L2_W'(hi_r) * L2_W'(hi_r);
        mean_ok_r <= ((ML_W'(wsum_r) << 4) <= ML_W'(mln_r));
      end
      S_ROOT_GO: begin
        ok_r <= mean_ok_r && (CMP_W'(lo2_r) <= x256) && (x256 <= CMP_W'(hi2_r));
      end
      S_ROOT_WAIT: if (root_done) root_r <= root;
      S_DIVM_WAIT: if (div_done) mean_r <= quot;
      S_DIVS_WAIT: if (div_done) sd_r <= quot;
      S_ENH:       prod_r <= centre_r * cfg_gain_r;
      default:     ;
    endcase
  end

  lse_root #(
    .X_W (X_W),
    .R_W (R_W)
  ) u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_ROOT_GO),
    .x     (x_r),
    .done  (root_done),
    .root  (root)
  );

  lse_div #(
    .N_W (N_W),
    .D_W (D_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    ((state_r == S_DIVM_GO) || (state_r == S_DIVS_GO)),
    .dividend ((state_r == S_DIVM_GO) ? D_W'(wsum_r) : D_W'(root_r)),
    .divisor  (n_r),
    .done     (div_done),
    .quot     (quot)
  );

  // Output register.
  logic [11:0] gained;
  logic [7:0]  gained_sat;
  logic        out_valid_r;
  logic [7:0]  out_mean_r;
  logic [7:0]  out_sd_r;
  logic [7:0]  out_pix_r;
  logic        out_enh_r;
  logic        out_end_r;

  assign gained     = prod_r[15:4];
  assign gained_sat = (gained > 12'd255) ? 8'd255 : gained[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && out_free) begin
      out_mean_r <= mean_r;
      out_sd_r   <= sd_r;
      out_pix_r  <= ok_r ? gained_sat : centre_r;
      out_enh_r  <= ok_r;
      out_end_r  <= frame_end_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_local_mean     = out_mean_r;
  assign out_local_sd       = out_sd_r;
  assign out_enhanced_pixel = out_pix_r;
  assign out_was_enhanced   = out_enh_r;
  assign out_frame_end      = out_end_r;

  // The position always stays inside the latched frame and the slot ring.
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (ROWS_W'(row_r) < rows_r) && (CW1'(col_r) < width_r))
    else $error("pixel position outside the latched frame");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r < SL_W'(MAX_WINDOW))
    else $error("line store slot out of range");

  // The root unit only reports while the sequencer waits for it.
  a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> (state_r == S_ROOT_WAIT))
    else $error("square root finished outside its wait state");

  // A finished result is loaded only into a free output register.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_OUT) && out_free) |=> out_valid_r && (state_r == S_IDLE))
    else $error("result not presented after load");

endmodule
